[rtl/core/orp_trimmed_mean_converter_unit_macros.svh]
// Assertion macros used by the converter's top-level RTL file.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ORP_TRIMMED_MEAN_CONVERTER_UNIT_MACROS_SVH
`define ORP_TRIMMED_MEAN_CONVERTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tmc_pkg.sv]
package tmc_pkg;

    // Conversion constants, in whole millivolts, converter codes or bit counts.
    localparam int REF_MV        = 5000;
    localparam int REF_MV_BITS   = 13;
    localparam int ZERO_POINT_MV = 2000;
    localparam int FS_SHIFT      = 10;
    localparam int OFFSET_BITS   = 12;
    localparam int ORP_BITS      = 14;
    localparam int OUT_MIN       = -8192;
    localparam int OUT_MAX       = 8191;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_TRIM = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DIV  = 5'b10000
    } tmc_state_t;

    // Control from the sequencer to the scan accumulator.
    typedef struct packed {
        logic clear;
        logic take;
    } scan_ctl_t;

endpackage

[rtl/core/orp_trimmed_mean_converter_unit.sv]
// ORP trimmed-mean converter. Each accepted sample is written into a ring of
// DEPTH entries (all zero after reset), then the whole ring is read back one
// entry per cycle to form its sum, minimum and maximum; the trimmed sum is
// scaled by 5000, shifted down by 10 and divided by DEPTH-2 through a multiply
// by its reciprocal, and the result is 2000 minus that quotient minus the
// offset, in millivolts, saturated to 14 bits. A new sample is accepted only
// once the previous result has been moved into the output register, so the
// block does not take a sample while another is in flight. The ring is scanned
// through its single read port. in_ready is high only while the block is idle
// and no finished result is pending; a finished result waits until the output
// register is free and holds off the next sample until then.
// The offset is applied when a result is formed, so write it through
// cfg_valid/cfg_data only while no item is in flight.
`include "orp_trimmed_mean_converter_unit_macros.svh"

module orp_trimmed_mean_converter_unit #(
    parameter int DEPTH       = 40,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [SAMPLE_BITS-1:0]                sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [tmc_pkg::ORP_BITS-1:0]   orp_mv,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic signed [tmc_pkg::OFFSET_BITS-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int PW = SW + tmc_pkg::REF_MV_BITS;
    localparam int NW = PW - tmc_pkg::FS_SHIFT;
    localparam int RW = NW + 3;

    tmc_pkg::tmc_state_t state_reg;
    tmc_pkg::tmc_state_t state_next;

    logic [AW-1:0]                         wptr_reg;
    logic [CW-1:0]                         cnt_reg;
    logic                                  take_reg;
    logic signed [tmc_pkg::OFFSET_BITS-1:0] offset_reg;
    logic [SW-1:0]                         trim_reg;
    logic                                  out_valid_reg;
    logic signed [tmc_pkg::ORP_BITS-1:0]   orp_reg;
    logic                                  pending_reg;

    logic                   accept;
    logic                   rd_en;
    logic [SAMPLE_BITS-1:0] rd_data;
    tmc_pkg::scan_ctl_t     scan_ctl;
    logic [SW-1:0]          sum;
    logic [SAMPLE_BITS-1:0] min_val;
    logic [SAMPLE_BITS-1:0] max_val;
    logic [PW-1:0]          product;
    logic                   div_start;
    logic                   div_done;
    logic [NW-1:0]          quotient;
    logic signed [RW-1:0]   mv;
    logic signed [tmc_pkg::ORP_BITS-1:0] mv_sat;
    logic                   load_out;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == tmc_pkg::ST_IDLE) && !pending_reg;
    assign cfg_ready = 1'b1;
    assign rd_en     = (state_reg == tmc_pkg::ST_SCAN) && (cnt_reg != CW'(DEPTH));

    tmc_ring #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (wptr_reg),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign scan_ctl.clear = accept;
    assign scan_ctl.take  = take_reg;

    tmc_scan #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SW)
    ) u_scan (
        .clk     (clk),
        .ctl     (scan_ctl),
        .value   (rd_data),
        .sum     (sum),
        .min_val (min_val),
        .max_val (max_val)
    );

    // The scale by 5000 feeds the divider's dividend register directly.
    assign product   = PW'(trim_reg) * PW'(tmc_pkg::REF_MV);
    assign div_start = (state_reg == tmc_pkg::ST_MUL);

    tmc_divider #(
        .NUM_BITS (NW),
        .DIVISOR  (DEPTH - 2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product[PW-1:tmc_pkg::FS_SHIFT]),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        mv = RW'(tmc_pkg::ZERO_POINT_MV) - signed'(RW'(quotient)) - RW'(offset_reg);
        if (mv < RW'(tmc_pkg::OUT_MIN))
        begin
            mv_sat = tmc_pkg::ORP_BITS'(tmc_pkg::OUT_MIN);
        end
        else if (mv > RW'(tmc_pkg::OUT_MAX))
        begin
            mv_sat = tmc_pkg::ORP_BITS'(tmc_pkg::OUT_MAX);
        end
        else
        begin
            mv_sat = mv[tmc_pkg::ORP_BITS-1:0];
        end
    end

    // A finished quotient is moved to the output register once it is free.
    assign load_out = pending_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tmc_pkg::ST_SCAN;
                end
            end
            tmc_pkg::ST_SCAN:
            begin
                if (cnt_reg == CW'(DEPTH))
                begin
                    state_next = tmc_pkg::ST_TRIM;
                end
            end
            tmc_pkg::ST_TRIM:
            begin
                state_next = tmc_pkg::ST_MUL;
            end
            tmc_pkg::ST_MUL:
            begin
                state_next = tmc_pkg::ST_DIV;
            end
            tmc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = tmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tmc_pkg::ST_TRIM)
        begin
            trim_reg <= sum - SW'(min_val) - SW'(max_val);
        end
        if (load_out)
        begin
            orp_reg <= mv_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmc_pkg::ST_IDLE;
            wptr_reg      <= '0;
            cnt_reg       <= '0;
            take_reg      <= 1'b0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            take_reg  <= rd_en;
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= cfg_data;
            end
            if (accept)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                cnt_reg  <= '0;
            end
            else if (rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if ((state_reg == tmc_pkg::ST_DIV) && div_done)
            begin
                pending_reg <= 1'b1;
            end
            else if (load_out)
            begin
                pending_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign orp_mv    = orp_reg;

    `TMC_ASSERT_SAME(a_min_le_max, state_reg == tmc_pkg::ST_TRIM,
        min_val <= max_val, "scan produced minimum above maximum")
    `TMC_ASSERT_SAME(a_sum_covers, state_reg == tmc_pkg::ST_TRIM,
        sum >= SW'(min_val) + SW'(max_val), "sum smaller than minimum plus maximum")
    `TMC_ASSERT_SAME(a_done_in_div, div_done,
        state_reg == tmc_pkg::ST_DIV, "divider finished outside the divide phase")
    `TMC_ASSERT_NEXT(a_load_shows, load_out,
        out_valid_reg && !pending_reg, "loaded result not offered")
    `TMC_ASSERT_SAME(a_scan_bound, state_reg == tmc_pkg::ST_SCAN,
        cnt_reg <= CW'(DEPTH), "scan address past the ring")

endmodule

[rtl/core/tmc_ring.sv]
module tmc_ring #(
    parameter int DEPTH       = 40,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [SAMPLE_BITS-1:0]     wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [SAMPLE_BITS-1:0]     rd_data
);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]       valid_reg;
    logic [SAMPLE_BITS-1:0] rd_q_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

[rtl/core/tmc_scan.sv]
module tmc_scan #(
    parameter int SAMPLE_BITS = 10,
    parameter int SUM_BITS    = 16
) (
    input  logic                   clk,
    input  tmc_pkg::scan_ctl_t     ctl,
    input  logic [SAMPLE_BITS-1:0] value,
    output logic [SUM_BITS-1:0]    sum,
    output logic [SAMPLE_BITS-1:0] min_val,
    output logic [SAMPLE_BITS-1:0] max_val
);

    logic [SUM_BITS-1:0]    sum_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            sum_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
        end
        else if (ctl.take)
        begin
            sum_reg <= sum_reg + SUM_BITS'(value);
            if (value < min_reg)
            begin
                min_reg <= value;
            end
            if (value > max_reg)
            begin
                max_reg <= value;
            end
        end
    end

    assign sum     = sum_reg;
    assign min_val = min_reg;
    assign max_val = max_reg;

endmodule

[rtl/core/tmc_divider.sv]
module tmc_divider #(
    parameter int NUM_BITS = 19,
    parameter int DIVISOR  = 38
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    output logic                done,
    output logic [NUM_BITS-1:0] quotient
);

    localparam int SHIFT  = NUM_BITS + $clog2(DIVISOR);
    localparam int M_BITS = NUM_BITS + 1;
    localparam int P_BITS = NUM_BITS + M_BITS;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [M_BITS-1:0] RECIP = RECIP_FULL[M_BITS-1:0];

    logic [NUM_BITS-1:0] dvd_reg;
    logic [NUM_BITS-1:0] quo_reg;
    logic [P_BITS-1:0]   prod;
    logic                mul_reg;
    logic                done_reg;

    // Division by a constant: multiply by the rounded-up reciprocal and keep the
    // high bits. The rounding error stays below one step of the quotient for
    // every dividend of NUM_BITS bits, so the result is the exact floor.
    assign prod = P_BITS'(dvd_reg) * P_BITS'(RECIP);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
        end
        if (mul_reg)
        begin
            quo_reg <= NUM_BITS'(prod >> SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= start;
            done_reg <= mul_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
